// ----- rtl/core/wsg_pkg.sv -----
// shared constants, types and the sine table of the waveform sample generator
package wsg_pkg;

  localparam int POINTS   = 128;
  localparam int PHASE_W  = $clog2(POINTS);
  localparam int DATA_W   = 12;
  localparam int PROD_W   = 2 * DATA_W;
  localparam int DUTY_W   = 7;
  localparam int SHAPE_W  = 2;
  localparam int ADDR_W   = 5;
  localparam int PDATA_W  = 32;

  localparam logic [DATA_W-1:0] SAMPLE_MAX = 12'd4095;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;

  // duty * 128 / 100 == (duty * 5243) >> 12 for duty up to 100
  localparam int SPLIT_RECIP = 5243;
  localparam int SPLIT_SHIFT = 12;
  localparam int SPLIT_W     = 20;

  localparam logic [SHAPE_W-1:0] SHAPE_RECT = 2'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_SINE = 2'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_TRI  = 2'd2;

  localparam logic [2:0] REG_WAVE_SHAPE   = 3'd0;
  localparam logic [2:0] REG_LOW_LEVEL    = 3'd1;
  localparam logic [2:0] REG_HIGH_LEVEL   = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE    = 3'd3;
  localparam logic [2:0] REG_DUTY_PERCENT = 3'd4;

  localparam logic [SHAPE_W-1:0] RST_WAVE_SHAPE   = SHAPE_SINE;
  localparam logic [DATA_W-1:0]  RST_LOW_LEVEL    = 12'd0;
  localparam logic [DATA_W-1:0]  RST_HIGH_LEVEL   = 12'd4095;
  localparam logic [DATA_W-1:0]  RST_AMPLITUDE    = 12'd4095;
  localparam logic [DUTY_W-1:0]  RST_DUTY_PERCENT = 7'd50;

  typedef struct packed {
    logic [SHAPE_W-1:0] wave_shape;
    logic [DATA_W-1:0]  low_level;
    logic [DATA_W-1:0]  high_level;
    logic [DATA_W-1:0]  amplitude;
    logic [DUTY_W-1:0]  duty_percent;
  } wsg_cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_init;
    logic div_step;
    logic fin;
  } wsg_cmd_t;

  typedef struct packed {
    logic use_mul;
    logic use_div;
  } wsg_sts_t;

  localparam logic [DATA_W-1:0] SINE_TAB [POINTS] = '{
    12'd2047, 12'd2147, 12'd2248, 12'd2347, 12'd2446, 12'd2544, 12'd2641, 12'd2737,
    12'd2830, 12'd2922, 12'd3012, 12'd3099, 12'd3184, 12'd3266, 12'd3346, 12'd3422,
    12'd3494, 12'd3564, 12'd3629, 12'd3691, 12'd3749, 12'd3803, 12'd3852, 12'd3897,
    12'd3938, 12'd3974, 12'd4006, 12'd4033, 12'd4055, 12'd4072, 12'd4084, 12'd4092,
    12'd4094, 12'd4092, 12'd4084, 12'd4072, 12'd4055, 12'd4033, 12'd4006, 12'd3974,
    12'd3938, 12'd3897, 12'd3852, 12'd3803, 12'd3749, 12'd3691, 12'd3629, 12'd3564,
    12'd3494, 12'd3422, 12'd3346, 12'd3266, 12'd3184, 12'd3099, 12'd3012, 12'd2922,
    12'd2830, 12'd2737, 12'd2641, 12'd2544, 12'd2446, 12'd2347, 12'd2248, 12'd2147,
    12'd2047, 12'd1947, 12'd1846, 12'd1747, 12'd1648, 12'd1550, 12'd1453, 12'd1357,
    12'd1264, 12'd1172, 12'd1082, 12'd995,  12'd910,  12'd828,  12'd748,  12'd672,
    12'd600,  12'd530,  12'd465,  12'd403,  12'd345,  12'd291,  12'd242,  12'd197,
    12'd156,  12'd120,  12'd88,   12'd61,   12'd39,   12'd22,   12'd10,   12'd2,
    12'd0,    12'd2,    12'd10,   12'd22,   12'd39,   12'd61,   12'd88,   12'd120,
    12'd156,  12'd197,  12'd242,  12'd291,  12'd345,  12'd403,  12'd465,  12'd530,
    12'd600,  12'd672,  12'd748,  12'd828,  12'd910,  12'd995,  12'd1082, 12'd1172,
    12'd1264, 12'd1357, 12'd1453, 12'd1550, 12'd1648, 12'd1747, 12'd1846, 12'd1947
  };

endpackage

// ----- rtl/core/wsg_in_if.sv -----
// input word channel carrying the restart flag
interface wsg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// ----- rtl/core/wsg_out_if.sv -----
// result word channel carrying the sample and period end flag
interface wsg_out_if;
  logic                      valid;
  logic                      ready;
  logic [wsg_pkg::DATA_W-1:0] sample;
  logic                      period_end;

  modport source (output valid, output sample, output period_end, input ready);
  modport sink   (input valid, input sample, input period_end, output ready);
endinterface

// ----- rtl/core/waveform_sample_generator.sv -----
// waveform sample generator top level
// sequence: rectangle and unused shape go from accept straight to the output register, sine
// adds a multiply, triangle a multiply, then a 12-step restoring divider, one quotient bit a cycle
// a new word is accepted only once the previous result is in the output register, which waits while a word is untaken
// reset: registers take their reset values, phase returns to zero, no word held
module waveform_sample_generator (
  input  logic                         clk,
  input  logic                         rst_n,
  wsg_in_if.sink                       in_ch,
  wsg_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [wsg_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [wsg_pkg::PDATA_W-1:0]  cfg_pwdata,
  output logic [wsg_pkg::PDATA_W-1:0]  cfg_prdata,
  output logic                         cfg_pready
);

  wsg_pkg::wsg_cfg_t cfg;
  wsg_pkg::wsg_cmd_t cmd;
  wsg_pkg::wsg_sts_t sts;

  wsg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  wsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wsg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .restart    (in_ch.restart),
    .sample     (out_ch.sample),
    .period_end (out_ch.period_end)
  );

endmodule

// ----- rtl/core/wsg_regs.sv -----
// apb configuration register file
module wsg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [wsg_pkg::ADDR_W-1:0]    cfg_paddr,
  input  logic [wsg_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [wsg_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready,
  output wsg_pkg::wsg_cfg_t             cfg
);

  wsg_pkg::wsg_cfg_t cfg_r;
  wsg_pkg::wsg_cfg_t cfg_nxt;
  logic              wr;
  logic [2:0]        idx;

  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[wsg_pkg::ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        wsg_pkg::REG_WAVE_SHAPE:   cfg_nxt.wave_shape   = cfg_pwdata[wsg_pkg::SHAPE_W-1:0];
        wsg_pkg::REG_LOW_LEVEL:    cfg_nxt.low_level    = cfg_pwdata[wsg_pkg::DATA_W-1:0];
        wsg_pkg::REG_HIGH_LEVEL:   cfg_nxt.high_level   = cfg_pwdata[wsg_pkg::DATA_W-1:0];
        wsg_pkg::REG_AMPLITUDE:    cfg_nxt.amplitude    = cfg_pwdata[wsg_pkg::DATA_W-1:0];
        wsg_pkg::REG_DUTY_PERCENT: cfg_nxt.duty_percent = cfg_pwdata[wsg_pkg::DUTY_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wsg_pkg::REG_WAVE_SHAPE:   cfg_prdata = 32'(cfg_r.wave_shape);
      wsg_pkg::REG_LOW_LEVEL:    cfg_prdata = 32'(cfg_r.low_level);
      wsg_pkg::REG_HIGH_LEVEL:   cfg_prdata = 32'(cfg_r.high_level);
      wsg_pkg::REG_AMPLITUDE:    cfg_prdata = 32'(cfg_r.amplitude);
      wsg_pkg::REG_DUTY_PERCENT: cfg_prdata = 32'(cfg_r.duty_percent);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_shape   <= wsg_pkg::RST_WAVE_SHAPE;
      cfg_r.low_level    <= wsg_pkg::RST_LOW_LEVEL;
      cfg_r.high_level   <= wsg_pkg::RST_HIGH_LEVEL;
      cfg_r.amplitude    <= wsg_pkg::RST_AMPLITUDE;
      cfg_r.duty_percent <= wsg_pkg::RST_DUTY_PERCENT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/wsg_ctrl.sv -----
// controller state machine sequencing accept, multiply, divide and output
module wsg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wsg_pkg::wsg_sts_t sts,
  output wsg_pkg::wsg_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam int                 CNT_W    = $clog2(wsg_pkg::DATA_W);
  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(wsg_pkg::DATA_W - 1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.use_mul ? S_MUL : S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sts.use_div ? S_INIT : S_FIN;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_fin_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid_r || out_ready))
    else $error("result written over an untaken word");

  a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r)
    else $error("finished word not presented");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_LAST) |=> (state_r == S_FIN))
    else $error("divider ran past its last step");

endmodule

// ----- rtl/core/wsg_dp.sv -----
// datapath: phase counter, shared multiplier, restoring divider and output register
module wsg_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wsg_pkg::wsg_cfg_t          cfg,
  input  wsg_pkg::wsg_cmd_t          cmd,
  output wsg_pkg::wsg_sts_t          sts,
  input  logic                       restart,
  output logic [wsg_pkg::DATA_W-1:0] sample,
  output logic                       period_end
);

  localparam int DW = wsg_pkg::DATA_W;
  localparam int PW = wsg_pkg::PHASE_W;
  localparam logic [PW-1:0] PHASE_LAST = PW'(wsg_pkg::POINTS - 1);

  logic [PW-1:0]                 phase_r, p_r;
  logic [wsg_pkg::PROD_W-1:0]    prod_r;
  logic [DW-1:0]                 div_r, rem_r, dvd_r;
  logic                          neg_r, up_r;
  logic [DW-1:0]                 sample_r;
  logic                          period_end_r;

  logic [PW-1:0]                 cur_phase;
  logic [wsg_pkg::DUTY_W-1:0]    duty;
  logic [wsg_pkg::SPLIT_W-1:0]   split_prod;
  logic [PW:0]                   split;
  logic [PW-1:0]                 mc;
  logic signed [DW:0]            diff;
  logic [DW:0]                   ndiff;
  logic [DW-1:0]                 absdiff;
  logic                          up;
  logic [PW-1:0]                 num, den;
  logic [PW:0]                   fall_den;
  logic [DW-1:0]                 mul_a, mul_b, divisor;
  logic [DW:0]                   trial;
  logic                          ge;
  logic signed [DW+1:0]          qs, tri_v;
  logic [DW-1:0]                 tri_s, sample_nxt;
  logic [wsg_pkg::PROD_W-1:0]    sine_sum;
  logic [DW-1:0]                 sine_q;

  assign sts.use_mul = (cfg.wave_shape inside {wsg_pkg::SHAPE_SINE, wsg_pkg::SHAPE_TRI});
  assign sts.use_div = (cfg.wave_shape == wsg_pkg::SHAPE_TRI);

  assign cur_phase  = restart ? '0 : phase_r;
  assign duty       = (cfg.duty_percent > wsg_pkg::DUTY_MAX) ? wsg_pkg::DUTY_MAX
                                                             : cfg.duty_percent;
  assign split_prod = wsg_pkg::SPLIT_W'(duty) * wsg_pkg::SPLIT_W'(wsg_pkg::SPLIT_RECIP);
  assign split      = split_prod[wsg_pkg::SPLIT_SHIFT +: PW+1];

  always_comb begin
    if (split == '0) begin
      mc = PW'(1);
    end else if (split[PW]) begin
      mc = PHASE_LAST;
    end else begin
      mc = split[PW-1:0];
    end
  end

  assign diff    = $signed({1'b0, cfg.high_level}) - $signed({1'b0, cfg.low_level});
  assign ndiff   = -diff;
  assign absdiff = diff[DW] ? ndiff[DW-1:0] : diff[DW-1:0];

  assign up       = (p_r < mc);
  assign fall_den = (PW+1)'(wsg_pkg::POINTS) - {1'b0, mc};
  assign num      = up ? p_r : (p_r - mc);
  assign den      = up ? mc : fall_den[PW-1:0];
  assign divisor  = DW'(den);

  always_comb begin
    if (cfg.wave_shape == wsg_pkg::SHAPE_SINE) begin
      mul_a = wsg_pkg::SINE_TAB[p_r];
      mul_b = cfg.amplitude;
    end else begin
      mul_a = absdiff;
      mul_b = DW'(num);
    end
  end

  // x / 4095 == (x + (x >> 12) + 1) >> 12 for x below 4095 * 4096
  assign sine_sum = prod_r + wsg_pkg::PROD_W'(prod_r[wsg_pkg::PROD_W-1:DW])
                  + wsg_pkg::PROD_W'(1);
  assign sine_q   = sine_sum[wsg_pkg::PROD_W-1:DW];

  assign trial = {rem_r, dvd_r[DW-1]};
  assign ge    = (trial >= {1'b0, div_r});

  // dvd_r holds the quotient once all steps are done
  assign qs    = neg_r ? -$signed({2'b00, dvd_r}) : $signed({2'b00, dvd_r});
  assign tri_v = up_r ? ($signed({2'b00, cfg.low_level}) + qs)
                      : ($signed({2'b00, cfg.high_level}) - qs);

  always_comb begin
    if (tri_v < 0) begin
      tri_s = '0;
    end else if (tri_v > $signed({2'b00, wsg_pkg::SAMPLE_MAX})) begin
      tri_s = wsg_pkg::SAMPLE_MAX;
    end else begin
      tri_s = tri_v[DW-1:0];
    end
  end

  always_comb begin
    case (cfg.wave_shape)
      wsg_pkg::SHAPE_RECT: sample_nxt = ({1'b0, p_r} < split) ? cfg.high_level
                                                              : cfg.low_level;
      wsg_pkg::SHAPE_SINE: sample_nxt = sine_q;
      wsg_pkg::SHAPE_TRI:  sample_nxt = tri_s;
      default:             sample_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (cmd.load) begin
      phase_r <= cur_phase + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p_r <= cur_phase;
    end
    if (cmd.mul) begin
      prod_r <= wsg_pkg::PROD_W'(mul_a) * wsg_pkg::PROD_W'(mul_b);
      div_r  <= divisor;
      neg_r  <= diff[DW];
      up_r   <= up;
    end
    if (cmd.div_init) begin
      rem_r <= prod_r[wsg_pkg::PROD_W-1:DW];
      dvd_r <= prod_r[DW-1:0];
    end else if (cmd.div_step) begin
      rem_r <= ge ? DW'(trial - {1'b0, div_r}) : trial[DW-1:0];
      dvd_r <= {dvd_r[DW-2:0], ge};
    end
    if (cmd.fin) begin
      sample_r     <= sample_nxt;
      period_end_r <= (p_r == PHASE_LAST);
    end
  end

  assign sample     = sample_r;
  assign period_end = period_end_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < div_r))
    else $error("divider remainder out of range");

  a_tri_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && cfg.wave_shape == wsg_pkg::SHAPE_TRI) |-> (dvd_r <= absdiff))
    else $error("triangle step exceeds level span");

  a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (phase_r == PW'(p_r + 1'b1)))
    else $error("phase did not advance past the sampled point");

endmodule
